>>> hdl/tbpf_pkg.sv
// Shared constants, codes and controller/datapath interface types for the tile pixel fetch.
package tbpf_pkg;

    // Video memory: 8 KiB of bytes held as two 4096-byte banks (even and odd offsets)
    localparam int VIDEO_BYTES = 8192;
    localparam int ADDR_W      = $clog2(VIDEO_BYTES);
    localparam int BANK_DEPTH  = VIDEO_BYTES / 2;
    localparam int BANK_AW     = ADDR_W - 1;

    // Stream payload widths
    localparam int S_TDATA_W = 40;  // 13 + 8 + 8 + 8 = 37 bits, padded to bytes
    localparam int M_TDATA_W = 16;  // 2 + 9 = 11 bits, padded to bytes
    localparam int TILE_W    = 9;

    // Item kinds carried in the input tuser bit
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_SELECT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_SELECT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PALETTE     = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic               accept;      // input item taken this cycle
        logic               clr_we;      // clearing pass writes zero to both banks
        logic [BANK_AW-1:0] clr_addr;    // row being cleared
        logic               tile_rd;     // read both bitplane bytes of the tile row
        logic               load_fetch;  // move fetch shade into the output register
        logic               load_write;  // move write result into the output register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;  // output register empty or being emptied this cycle
        logic in_fetch;  // kind of the item offered at the input
    } t_dp_sts;

endpackage

>>> hdl/tbpf_ctrl.sv
// Sequencer for the tile pixel fetch: clearing pass, item acceptance and result hand-off.
module tbpf_ctrl
    import tbpf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_axis_tvalid,
    output logic    o_s_axis_tready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TILE,
        ST_SHADE,
        ST_WDONE
    } t_state;

    t_state             r_state, n_state;
    logic [BANK_AW-1:0] r_clr_addr, n_clr_addr;
    logic               w_ready;
    logic               w_accept;

    // Take a new item when idle or when the pending result leaves this cycle
    always_comb begin
        case (r_state)
            ST_IDLE:  w_ready = 1'b1;
            ST_SHADE: w_ready = i_sts.out_free;
            ST_WDONE: w_ready = i_sts.out_free;
            default:  w_ready = 1'b0;
        endcase
    end

    assign w_accept        = i_s_axis_tvalid && w_ready;
    assign o_s_axis_tready = w_ready;

    // Next state and clear counter
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (&r_clr_addr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE, ST_SHADE, ST_WDONE: begin
                if (w_accept) begin
                    n_state = i_sts.in_fetch ? ST_TILE : ST_WDONE;
                end else if (r_state != ST_IDLE && i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_TILE: n_state = ST_SHADE;
            default: n_state = ST_CLEAR;
        endcase
    end

    // Hold state and clear counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
        end
    end

    // Drive datapath commands
    always_comb begin
        o_cmd            = '0;
        o_cmd.accept     = w_accept;
        o_cmd.clr_we     = (r_state == ST_CLEAR);
        o_cmd.clr_addr   = r_clr_addr;
        o_cmd.tile_rd    = (r_state == ST_TILE);
        o_cmd.load_fetch = (r_state == ST_SHADE) && i_sts.out_free;
        o_cmd.load_write = (r_state == ST_WDONE) && i_sts.out_free;
    end

    // Clearing writes never collide with an item
    a_clr_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clr_we |-> !o_cmd.accept)
        else $error("item accepted during clearing pass");

    // A tile row read is always followed by the shade step
    a_tile_then_shade: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_TILE |=> r_state == ST_SHADE)
        else $error("tile read not followed by shade step");

    // Only one result moves into the output register at a time
    a_one_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load_fetch, o_cmd.load_write}))
        else $error("two results loaded at once");

    // A fetch item needs both memory reads before its result is loaded
    a_fetch_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_fetch |-> $past(o_cmd.tile_rd) || $past(r_state == ST_SHADE))
        else $error("fetch result loaded without tile read");

endmodule

>>> hdl/tbpf_datapath.sv
// Video memory banks, configuration registers, address forming, shading and output register.
module tbpf_datapath
    import tbpf_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    output t_dp_sts                o_sts,
    input  logic [S_TDATA_W-1:0]   i_s_axis_tdata,
    input  logic                   i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [M_TDATA_W-1:0]   o_m_axis_tdata,
    output logic                   o_m_axis_tuser,
    input  logic                   i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [7:0]             i_cfg_data
);

    // Input fields
    logic [ADDR_W-1:0] w_offset;
    logic [7:0]        w_wbyte;
    logic [7:0]        w_px;
    logic [7:0]        w_py;

    assign w_offset = i_s_axis_tdata[12:0];
    assign w_wbyte  = i_s_axis_tdata[20:13];
    assign w_px     = i_s_axis_tdata[28:21];
    assign w_py     = i_s_axis_tdata[36:29];

    // Configuration registers
    logic       r_map_select;
    logic       r_data_select;
    logic [7:0] r_palette;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_select  <= 1'b0;
            r_data_select <= 1'b0;
            r_palette     <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAP_SELECT:  r_map_select  <= i_cfg_data[0];
                CFG_DATA_SELECT: r_data_select <= i_cfg_data[0];
                CFG_PALETTE:     r_palette     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Fetch context
    logic       r_map_lsb;
    logic [2:0] r_px_lo;
    logic [2:0] r_py_lo;
    logic       w_fetch_acc;
    logic       w_write_acc;

    assign w_fetch_acc = i_cmd.accept && (i_s_axis_tuser == OP_FETCH);
    assign w_write_acc = i_cmd.accept && (i_s_axis_tuser == OP_WRITE);

    always_ff @(posedge i_clk) begin
        if (w_fetch_acc) begin
            r_map_lsb <= w_px[3];
            r_px_lo   <= w_px[2:0];
            r_py_lo   <= w_py[2:0];
        end
    end

    // Bank read data and selected tile number
    logic [7:0]         r_even_q;
    logic [7:0]         r_odd_q;
    logic [7:0]         w_tile_num;
    logic [BANK_AW-1:0] w_map_row;
    logic [BANK_AW-1:0] w_tile_row;
    logic [BANK_AW-1:0] w_rd_addr;
    logic               w_rd_en;

    assign w_tile_num = r_map_lsb ? r_odd_q : r_even_q;

    // Tile map entry: base 0x1800 or 0x1C00, row y/8, column x/8
    assign w_map_row = {2'b11, r_map_select, w_py[7:3], w_px[7:4]};

    // Tile row: unsigned base 0, signed base 0x1000; plane pair at y%8 * 2
    assign w_tile_row = {~r_data_select & ~w_tile_num[7], w_tile_num[7],
                         w_tile_num[6:0], r_py_lo};

    assign w_rd_en   = w_fetch_acc || i_cmd.tile_rd;
    assign w_rd_addr = i_cmd.tile_rd ? w_tile_row : w_map_row;

    // Bank write side: clearing pass or a write item
    logic               w_we_even;
    logic               w_we_odd;
    logic [BANK_AW-1:0] w_wr_addr;
    logic [7:0]         w_wr_data;

    assign w_we_even = i_cmd.clr_we || (w_write_acc && !w_offset[0]);
    assign w_we_odd  = i_cmd.clr_we || (w_write_acc && w_offset[0]);
    assign w_wr_addr = i_cmd.clr_we ? i_cmd.clr_addr : w_offset[ADDR_W-1:1];
    assign w_wr_data = i_cmd.clr_we ? 8'd0 : w_wbyte;

    // Even-offset bank: low bitplanes
    logic [7:0] r_mem_even [BANK_DEPTH];

    always_ff @(posedge i_clk) begin
        if (w_we_even) begin
            r_mem_even[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_even_q <= r_mem_even[w_rd_addr];
        end
    end

    // Odd-offset bank: high bitplanes
    logic [7:0] r_mem_odd [BANK_DEPTH];

    always_ff @(posedge i_clk) begin
        if (w_we_odd) begin
            r_mem_odd[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_odd_q <= r_mem_odd[w_rd_addr];
        end
    end

    // Write result: report the tile index for writes below 0x1800
    logic              r_wr_changed;
    logic [TILE_W-1:0] r_wr_tile;
    logic              w_changed;

    assign w_changed = !(w_offset[12] && w_offset[11]);

    always_ff @(posedge i_clk) begin
        if (w_write_acc) begin
            r_wr_changed <= w_changed;
            r_wr_tile    <= w_changed ? w_offset[12:4] : '0;
        end
    end

    // Pixel shade: bit 7 is the leftmost pixel, low plane gives colour bit 0
    logic [2:0] w_bit;
    logic [1:0] w_colour;
    logic [1:0] w_shade;

    assign w_bit    = 3'd7 - r_px_lo;
    assign w_colour = {r_odd_q[w_bit], r_even_q[w_bit]};
    assign w_shade  = r_palette[{w_colour, 1'b0} +: 2];

    // Output register
    logic              r_out_valid;
    logic [1:0]        r_out_shade;
    logic              r_out_changed;
    logic [TILE_W-1:0] r_out_tile;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_fetch || i_cmd.load_write) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_fetch) begin
            r_out_shade   <= w_shade;
            r_out_changed <= 1'b0;
            r_out_tile    <= '0;
        end else if (i_cmd.load_write) begin
            r_out_shade   <= 2'd0;
            r_out_changed <= r_wr_changed;
            r_out_tile    <= r_wr_tile;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(M_TDATA_W - TILE_W - 2){1'b0}}, r_out_tile, r_out_shade};
    assign o_m_axis_tuser  = r_out_changed;

    // Status to the controller
    assign o_sts.out_free = !r_out_valid || i_m_axis_tready;
    assign o_sts.in_fetch = (i_s_axis_tuser == OP_FETCH);

endmodule

>>> hdl/tile_background_pixel_fetch.sv
// A write item's result is loaded from the WDONE state, a fetch item's from SHADE after TILE.
// Throughput: one write item per cycle unless output stalls; no item is taken in TILE, as the
// tile row read depends on the tile map read on the single read port of each video memory bank.
// Reset (synchronous, active low) clears the configuration and the output register, then runs
// a clearing pass over all 4096 rows of both banks; no item is accepted during that pass.
// Configuration writes are taken at any time, one per cycle.
module tile_background_pixel_fetch
    import tbpf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,  // mem_offset, write_byte, pixel_x, pixel_y
    input  logic                 i_s_axis_tuser,  // opcode
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,  // shade, changed_tile
    output logic                 o_m_axis_tuser,  // tile_changed
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    assign o_cfg_ready = 1'b1;

    tbpf_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_sts           (w_sts),
        .o_cmd           (w_cmd)
    );

    tbpf_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

endmodule
